// File: sv/mmsv_pkg.sv
// Shared types and constants for the monophonic square-wave voice.
package mmsv_pkg;

  // Input mode codes as they arrive on the event channel.
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_NOTE_ON  = 3'd1;
  localparam logic [2:0] MODE_NOTE_OFF = 3'd2;
  localparam logic [2:0] MODE_VOLUME   = 3'd3;
  localparam logic [2:0] MODE_ALL_OFF  = 3'd4;

  localparam int unsigned NOTES_PER_OCTAVE = 12;
  localparam int unsigned TOP_OCTAVE       = 10;
  localparam int unsigned NOTE_COUNT       = 128;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [6:0] VOLUME_RESET = 7'd64;
  localparam logic [6:0] VELOCITY_MAX = 7'd127;

  // Top octave (notes 120..131) in unsigned Q16 Hz.
  localparam logic [31:0] TOP_OCTAVE_Q16 [NOTES_PER_OCTAVE] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
  };

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_VOLUME,
    CMD_ALL_OFF
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [6:0] note;
    logic [6:0] value;
  } cmd_t;

endpackage

// File: sv/mmsv_in_if.sv
// Event channel: mode plus note, velocity and controller fields.
interface mmsv_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] note_number;
  logic [6:0] velocity;
  logic [6:0] control_value;

  modport source (output valid, mode, note_number, velocity, control_value, input ready);
  modport sink   (input valid, mode, note_number, velocity, control_value, output ready);
endinterface

// File: sv/mmsv_out_if.sv
// Sample channel: signed square-wave sample and voice activity flag.
interface mmsv_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] sample;
  logic               voice_active;

  modport source (output valid, sample, voice_active, input ready);
  modport sink   (input valid, sample, voice_active, output ready);
endinterface

// File: sv/mmsv_front.sv
// Front end: accept events, classify them into commands, drop unused modes.
module mmsv_front (
  mmsv_in_if.sink      in_i,
  input  logic         full_i,
  output logic         push_o,
  output mmsv_pkg::cmd_t cmd_o
);

  logic known;

  always_comb begin
    known       = 1'b1;
    cmd_o.op    = mmsv_pkg::CMD_TICK;
    cmd_o.note  = in_i.note_number;
    cmd_o.value = in_i.velocity;
    case (in_i.mode)
      mmsv_pkg::MODE_TICK: cmd_o.op = mmsv_pkg::CMD_TICK;
      mmsv_pkg::MODE_NOTE_ON: begin
        // a note-on with zero velocity acts as a note-off
        cmd_o.op = (in_i.velocity != '0) ? mmsv_pkg::CMD_NOTE_ON : mmsv_pkg::CMD_NOTE_OFF;
      end
      mmsv_pkg::MODE_NOTE_OFF: cmd_o.op = mmsv_pkg::CMD_NOTE_OFF;
      mmsv_pkg::MODE_VOLUME: begin
        cmd_o.op    = mmsv_pkg::CMD_VOLUME;
        cmd_o.value = in_i.control_value;
      end
      mmsv_pkg::MODE_ALL_OFF: cmd_o.op = mmsv_pkg::CMD_ALL_OFF;
      default: known = 1'b0;
    endcase
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && known;

endmodule

// File: sv/mmsv_fifo.sv
// Short command queue between front end and voice engine.
module mmsv_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mmsv_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output mmsv_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  localparam int unsigned Depth = mmsv_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mmsv_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

// File: sv/mmsv_back.sv
// Voice engine: note state, phase accumulator, gain and output register.
module mmsv_back #(
  parameter int unsigned SAMPLE_RATE = 44100,
  parameter int unsigned PHASE_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  mmsv_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  mmsv_out_if.source     out_o
);

  // Per-note phase step, worked out at elaboration.
  logic [PHASE_BITS-1:0] step_rom [mmsv_pkg::NOTE_COUNT];

  for (genvar g = 0; g < mmsv_pkg::NOTE_COUNT; g++) begin : g_step
    localparam bit [63:0] Num =
      64'(mmsv_pkg::TOP_OCTAVE_Q16[g % mmsv_pkg::NOTES_PER_OCTAVE]) << (PHASE_BITS - 16);
    localparam bit [63:0] Den =
      64'(SAMPLE_RATE) << (mmsv_pkg::TOP_OCTAVE - g / mmsv_pkg::NOTES_PER_OCTAVE);
    localparam bit [63:0] Step = (Num + (Den >> 1)) / Den;
    assign step_rom[g] = PHASE_BITS'(Step);
  end

  logic                  vel_en_q;
  logic [6:0]            note_q, note_d;
  logic                  active_q, active_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] step_q, step_d;
  logic [6:0]            vel_q, vel_d;
  logic [6:0]            vol_q, vol_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [14:0]    sample_q, sample_d;
  logic                  voice_q, voice_d;
  logic                  is_tick, slot_free;
  logic [6:0]            gain_sel;
  logic [13:0]           gain;
  logic [14:0]           mag;

  assign is_tick   = (cmd_i.op == mmsv_pkg::CMD_TICK);
  assign slot_free = !out_valid_q || out_o.ready;
  assign pop_o     = !empty_i && (!is_tick || slot_free);

  assign gain_sel = vel_en_q ? vel_q : mmsv_pkg::VELOCITY_MAX;
  assign gain     = {7'b0, vol_q} * {7'b0, gain_sel};
  assign mag      = {1'b0, gain};

  always_comb begin
    note_d      = note_q;
    active_d    = active_q;
    phase_d     = phase_q;
    step_d      = step_q;
    vel_d       = vel_q;
    vol_d       = vol_q;
    sample_d    = sample_q;
    voice_d     = voice_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (pop_o) begin
      case (cmd_i.op)
        mmsv_pkg::CMD_TICK: begin
          out_valid_d = 1'b1;
          voice_d     = active_q;
          if (active_q) begin
            sample_d = phase_q[PHASE_BITS-1] ? -mag : mag;
            phase_d  = phase_q + step_q;
          end else begin
            sample_d = '0;
          end
        end
        mmsv_pkg::CMD_NOTE_ON: begin
          note_d   = cmd_i.note;
          step_d   = step_rom[cmd_i.note];
          vel_d    = cmd_i.value;
          active_d = 1'b1;
        end
        mmsv_pkg::CMD_NOTE_OFF: begin
          if (cmd_i.note == note_q) begin
            active_d = 1'b0;
          end
        end
        mmsv_pkg::CMD_VOLUME: vol_d = cmd_i.value;
        mmsv_pkg::CMD_ALL_OFF: begin
          active_d = 1'b0;
          phase_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_en_q    <= 1'b1;
      note_q      <= '0;
      active_q    <= 1'b0;
      phase_q     <= '0;
      step_q      <= '0;
      vel_q       <= '0;
      vol_q       <= mmsv_pkg::VOLUME_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vel_en_q <= cfg_wdata_i;
      end
      note_q      <= note_d;
      active_q    <= active_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      vel_q       <= vel_d;
      vol_q       <= vol_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    voice_q  <= voice_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sample       = sample_q;
  assign out_o.voice_active = voice_q;

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !voice_q |-> sample_q == '0)
    else $error("silent sample is not zero");

  a_all_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.op == mmsv_pkg::CMD_ALL_OFF |=> !active_q && phase_q == '0)
    else $error("all-notes-off left the voice running");

  a_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.op == mmsv_pkg::CMD_NOTE_ON |=> active_q && vel_q != '0)
    else $error("note-on did not start the voice");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("pending sample dropped");

endmodule

// File: sv/midi_mono_square_voice.sv
// Top level of the one-voice MIDI-driven square-wave synthesizer.
//
// Usage:
//   in_i carries events: mode 0 is a sample tick, 1 note on, 2 note off,
//   3 channel volume, 4 all notes off; modes 5..7 are dropped. Only a tick
//   produces a transfer on out_o: the signed sample (+gain, -gain or 0) and
//   voice_active. Gain is volume times velocity, or volume times 127 when
//   cfg_we_i writes cfg_wdata_i = 0 into the velocity-enable register.
//   Path: an accepted tick is pushed into the queue and popped by the voice
//   engine, and its sample is held in the output register for out_o.
//   Throughput: one event per cycle while the queue is not full; the voice
//   engine retires one command per cycle from a two-entry queue while it
//   is not empty, and the single output register lets a new tick retire
//   in the same cycle the previous sample transfers. Note-on pitch comes
//   from a per-note step table built at elaboration.
//   Reset: voice silent, phase and step zero, volume 64, velocity scaling
//   enabled, queue and output empty.
//   Stall: while a sample is pending and out_o is not ready, ticks wait in
//   the queue; note and volume events behind no tick still retire. When the
//   queue fills, in_i.ready drops until the receiver takes the sample.
module midi_mono_square_voice #(
  parameter int unsigned SAMPLE_RATE = 44100,
  parameter int unsigned PHASE_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  mmsv_in_if.sink    in_i,
  mmsv_out_if.source out_o
);

  mmsv_pkg::cmd_t front_cmd;
  mmsv_pkg::cmd_t queue_cmd;
  logic           push, full, pop, empty;

  // Classify events and drop unused modes.
  mmsv_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  // Decouple acceptance from the voice engine.
  mmsv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (empty)
  );

  // Advance the voice state and hold samples for the receiver.
  mmsv_back #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .PHASE_BITS  (PHASE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (queue_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
